@@ rtl/rmt_pkg.sv @@
// Package for the range minimum tree: widths, constants and controller states.
`timescale 1ns / 1ps

package rmt_pkg;

  // Field widths
  localparam int unsigned ValW = 31;
  localparam int unsigned PosW = 10;
  localparam int unsigned CntW = 11;

  // Empty node value
  localparam logic [ValW-1:0] AllOnes = {ValW{1'b1}};

  // Register reset value of used_leaves
  localparam logic [CntW-1:0] UsedReset = 11'd1024;

  // Input modes
  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_W_RD,
    S_W_MIN,
    S_Q_L,
    S_Q_R,
    S_Q_OUT
  } state_e;

endpackage

@@ rtl/rmt_in_if.sv @@
// Input channel: point writes and range queries.
`timescale 1ns / 1ps

interface rmt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [rmt_pkg::PosW-1:0]  position;
  logic [rmt_pkg::ValW-1:0]  new_value;
  logic [rmt_pkg::PosW-1:0]  range_low;
  logic [rmt_pkg::PosW-1:0]  range_high;

  modport source (output valid, mode, position, new_value, range_low, range_high,
                  input ready);
  modport sink   (input valid, mode, position, new_value, range_low, range_high,
                  output ready);
endinterface

@@ rtl/rmt_out_if.sv @@
// Output channel: range minimum results.
`timescale 1ns / 1ps

interface rmt_out_if;
  logic                      valid;
  logic                      ready;
  logic [rmt_pkg::ValW-1:0]  min_value;
  logic                      is_empty;

  modport source (output valid, min_value, is_empty, input ready);
  modport sink   (input valid, min_value, is_empty, output ready);
endinterface

@@ rtl/range_minimum_tree.sv @@
// Top level: segment tree range minimum store with point writes and queries.
//
// Items arrive on in_i (valid/ready). mode 0 writes new_value to leaf
// position and gives no result; a write at or past the used leaf count is
// dropped. mode 1 returns the minimum over range_low..range_high on out_o,
// with is_empty set and all ones for an empty or out-of-range interval.
// used_leaves is written through cfg_we_i/cfg_data_i; the user must do so
// only while the block idles, which the block itself does not enforce. One
// item is worked at a time; in_i.ready is high only between items. A point
// write makes one sibling read and one parent write-back per tree level
// through the single read port of the node memory. A dropped write leaves
// the block idle. A query walks the tree level by level, a left and a right
// step per level, with at most one node read per cycle; an empty interval
// goes straight to the output step.
// Results go to an output register: a stalled receiver holds the beat, and
// the next item is still accepted; a query finishing onto a held beat waits.
// After reset a clearing pass writes all ones into all 2*LEAVES nodes, one a
// cycle, with in_i.ready low; configuration writes are taken throughout.
`timescale 1ns / 1ps

module range_minimum_tree #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rmt_in_if.sink                     in_i,
  rmt_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [rmt_pkg::CntW-1:0]   cfg_data_i
);

  localparam int unsigned Depth = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned IW    = AW + 1;
  localparam int unsigned CW    = (IW > rmt_pkg::CntW) ? IW : rmt_pkg::CntW;
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);
  localparam logic [AW-1:0] LeafBase = AW'(LEAVES);
  localparam logic [IW-1:0] LeafBaseI = IW'(LEAVES);
  localparam logic [CW-1:0] LeavesC  = CW'(LEAVES);
  localparam logic [AW-1:0] RootIdx  = AW'(1);

  rmt_pkg::state_e state_q, state_d;

  logic [rmt_pkg::CntW-1:0] used_q;
  logic [AW-1:0]            clr_q, clr_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic [IW-1:0]            l_q, l_d, r_q, r_d;
  logic [rmt_pkg::ValW-1:0] best_q, best_d;
  logic                     pend_q, pend_d;
  logic                     empty_q, empty_d;
  logic                     out_valid_q, out_valid_d;
  logic [rmt_pkg::ValW-1:0] out_min_q;
  logic                     out_empty_q;
  logic                     out_load;

  // Memory ports
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [rmt_pkg::ValW-1:0] ram_wdata, ram_rdata;

  rmt_ram #(
    .Width (rmt_pkg::ValW),
    .Depth (Depth)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Decode of the incoming beat
  logic                     in_acc;
  logic [CW-1:0]            cnt, pos_c, lo_c, hi_c, hi_clip;
  logic                     wr_ok, q_empty;
  logic [rmt_pkg::ValW-1:0] folded, walk_min;

  assign in_acc  = in_i.valid && in_i.ready;
  assign cnt     = (CW'(used_q) > LeavesC) ? LeavesC : CW'(used_q);
  assign pos_c   = CW'(in_i.position);
  assign lo_c    = CW'(in_i.range_low);
  assign hi_c    = CW'(in_i.range_high);
  assign wr_ok   = pos_c < cnt;
  assign q_empty = (lo_c > hi_c) || (lo_c >= cnt);
  assign hi_clip = (hi_c >= cnt) ? (cnt - CW'(1)) : hi_c;

  // Fold of a pending node read into the running minimum
  assign folded   = (pend_q && (ram_rdata < best_q)) ? ram_rdata : best_q;
  // Parent minimum on the update path
  assign walk_min = (ram_rdata < best_q) ? ram_rdata : best_q;

  assign in_i.ready = (state_q == rmt_pkg::S_IDLE);
  assign out_load   = (state_q == rmt_pkg::S_Q_OUT) && (!out_valid_q || out_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmt_pkg::S_CLEAR: begin
        if (clr_q == LastAddr) state_d = rmt_pkg::S_IDLE;
      end
      rmt_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_i.mode == rmt_pkg::ModeQuery) begin
            state_d = q_empty ? rmt_pkg::S_Q_OUT : rmt_pkg::S_Q_L;
          end else if (wr_ok) begin
            state_d = rmt_pkg::S_W_RD;
          end
        end
      end
      rmt_pkg::S_W_RD: begin
        state_d = (idx_q == RootIdx) ? rmt_pkg::S_IDLE : rmt_pkg::S_W_MIN;
      end
      rmt_pkg::S_W_MIN: state_d = rmt_pkg::S_W_RD;
      rmt_pkg::S_Q_L: begin
        state_d = (l_q >= r_q) ? rmt_pkg::S_Q_OUT : rmt_pkg::S_Q_R;
      end
      rmt_pkg::S_Q_R: state_d = rmt_pkg::S_Q_L;
      rmt_pkg::S_Q_OUT: begin
        if (out_load) state_d = rmt_pkg::S_IDLE;
      end
      default: state_d = rmt_pkg::S_CLEAR;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    clr_d     = clr_q;
    idx_d     = idx_q;
    l_d       = l_q;
    r_d       = r_q;
    best_d    = best_q;
    pend_d    = 1'b0;
    empty_d   = empty_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = best_q;
    ram_re    = 1'b0;
    ram_raddr = idx_q ^ AW'(1);
    unique case (state_q)
      rmt_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = rmt_pkg::AllOnes;
        clr_d     = clr_q + AW'(1);
      end
      rmt_pkg::S_IDLE: begin
        best_d = rmt_pkg::AllOnes;
        if (in_acc) begin
          if (in_i.mode == rmt_pkg::ModeQuery) begin
            empty_d = q_empty;
            l_d     = LeafBaseI + IW'(lo_c);
            r_d     = LeafBaseI + IW'(hi_clip) + IW'(1);
          end else if (wr_ok) begin
            // leaf write; the walk to the root follows
            ram_we    = 1'b1;
            ram_waddr = LeafBase + AW'(pos_c);
            ram_wdata = in_i.new_value;
            idx_d     = LeafBase + AW'(pos_c);
            best_d    = in_i.new_value;
          end
        end
      end
      rmt_pkg::S_W_RD: begin
        // fetch the sibling of the current node
        ram_re = (idx_q != RootIdx);
      end
      rmt_pkg::S_W_MIN: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q >> 1;
        ram_wdata = walk_min;
        idx_d     = idx_q >> 1;
        best_d    = walk_min;
      end
      rmt_pkg::S_Q_L: begin
        best_d = folded;
        if ((l_q < r_q) && l_q[0]) begin
          ram_re    = 1'b1;
          ram_raddr = l_q[AW-1:0];
          l_d       = l_q + IW'(1);
          pend_d    = 1'b1;
        end
      end
      rmt_pkg::S_Q_R: begin
        best_d = folded;
        l_d    = l_q >> 1;
        if (r_q[0]) begin
          ram_re    = 1'b1;
          ram_raddr = r_q[AW-1:0] - AW'(1);
          r_d       = (r_q - IW'(1)) >> 1;
          pend_d    = 1'b1;
        end else begin
          r_d = r_q >> 1;
        end
      end
      rmt_pkg::S_Q_OUT: begin
        best_d = best_q;
      end
      default: begin
        best_d = best_q;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (out_load)    out_valid_d = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmt_pkg::S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      used_q      <= rmt_pkg::UsedReset;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) used_q <= cfg_data_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    l_q     <= l_d;
    r_q     <= r_d;
    best_q  <= best_d;
    empty_q <= empty_d;
    if (out_load) begin
      out_min_q   <= best_q;
      out_empty_q <= empty_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.min_value = out_min_q;
  assign out_o.is_empty  = out_empty_q;

  // Checks
  a_rise_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == rmt_pkg::S_Q_OUT))
    else $error("result beat appeared without a finished query");

  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmt_pkg::S_Q_L || state_q == rmt_pkg::S_Q_R ||
     state_q == rmt_pkg::S_Q_OUT) |-> !ram_we)
    else $error("node memory written during a query");

  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmt_pkg::S_Q_R) |-> (l_q <= r_q))
    else $error("query bounds crossed inside a level");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmt_pkg::S_CLEAR && clr_q == LastAddr) |=> (state_q == rmt_pkg::S_IDLE))
    else $error("clearing pass did not end at the last node");

endmodule

@@ rtl/rmt_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module rmt_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
